FILE: rtl/o2h_pkg.sv
// o2h_pkg: shared types, constants and helpers for the object-to-hex converter.
// Used by the parser, the emitter and the top level. No dependencies.
package o2h_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned HDR_BYTES  = 4;

    localparam logic [7:0] MAX_LINE_RESET = 8'd16;

    // record types
    localparam logic [7:0] TYPE_MIN     = 8'h02;
    localparam logic [7:0] TYPE_MODEND  = 8'h04;
    localparam logic [7:0] TYPE_CONTENT = 8'h06;
    localparam logic [7:0] TYPE_LIMIT   = 8'h22;

    // fixed characters
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_NL      = 8'h0A;
    localparam logic [7:0] CHAR_ERR     = 8'h00;

    // character slots of one output job
    localparam logic [SLOT_W-1:0] SLOT_COLON   = 4'd0;   // header nibbles follow: 1..8
    localparam logic [SLOT_W-1:0] SLOT_HDR_END = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_DATA_HI = 4'd9;
    localparam logic [SLOT_W-1:0] SLOT_DATA_LO = 4'd10;
    localparam logic [SLOT_W-1:0] SLOT_TAIL_HI = 4'd11;
    localparam logic [SLOT_W-1:0] SLOT_TAIL_LO = 4'd12;
    localparam logic [SLOT_W-1:0] SLOT_NL      = 4'd13;
    localparam logic [SLOT_W-1:0] SLOT_ERR     = 4'd14;

    // one run of characters caused by one input word
    typedef struct packed {
        logic [HDR_BYTES*8-1:0] hdr;      // four header bytes, first byte in the top bits
        logic [7:0]             data;     // byte printed at the data slots
        logic [7:0]             tail;     // byte printed at the tail slots
        logic [SLOT_W-1:0]      start;    // first slot
        logic                   tail_hex; // print tail byte after data
        logic                   newline;  // close with a newline
        logic                   fin;      // end-of-module line
    } o2h_job_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10)
        begin
            ch = 8'h30 + {4'h0, nib};
        end
        else
        begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

FILE: rtl/o2h_if.sv
// o2h_if: valid/ready channel interfaces for object bytes and hex characters.
// Depends on o2h_pkg for field widths.
interface o2h_byte_if;
    logic                          valid;
    logic                          ready;
    logic [o2h_pkg::BYTE_W-1:0]    in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface o2h_char_if;
    logic                          valid;
    logic                          ready;
    logic [o2h_pkg::CHAR_W-1:0]    out_char;
    logic                          last_of_run;
    logic                          bad_record;
    logic                          finished;

    modport source (output valid, output out_char, output last_of_run,
                    output bad_record, output finished, input ready);
    modport sink   (input valid, input out_char, input last_of_run,
                    input bad_record, input finished, output ready);
endinterface

FILE: rtl/o2h_parser.sv
// o2h_parser: object record parser; one word per cycle, unless the emitter
// stalls it, into a character job. Depends on o2h_pkg and o2h_if.
module o2h_parser #(
    parameter logic [7:0] MAX_LINE_RESET = o2h_pkg::MAX_LINE_RESET
) (
    input  logic              clk,
    input  logic              rst_n,
    o2h_byte_if.sink          byte_in,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_wdata,
    input  logic              job_ready,
    output logic              job_valid,
    output o2h_pkg::o2h_job_t job
);

    typedef enum logic [3:0] {
        PH_TYPE, PH_LEN_LO, PH_LEN_HI, PH_SKIP, PH_SEG, PH_ADDR_LO, PH_ADDR_HI,
        PH_DATA, PH_JUNK, PH_END_MOD, PH_END_SEG, PH_END_ALO, PH_END_AHI, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] rec_reg, rec_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  line_reg, line_next;
    logic [7:0]  chk_reg, chk_next;
    logic        halted_reg, halted_next;
    logic [7:0]  max_line_reg;

    logic        take;
    logic [7:0]  b;
    logic [15:0] len;
    logic        line_open;
    logic [7:0]  lim, n, line_cnt, base, sum, end_ck;
    logic [15:0] rec_after;

    assign byte_in.ready = job_ready;
    assign take          = byte_in.valid & job_ready;
    assign b             = byte_in.in_byte;
    assign len           = {b, rec_reg[7:0]};

    // data-phase arithmetic
    assign line_open = (line_reg == 8'd0);
    assign lim       = (max_line_reg == 8'd0) ? 8'd1 : max_line_reg;
    assign n         = (rec_reg > {8'h00, lim}) ? lim : rec_reg[7:0];
    assign rec_after = line_open ? (rec_reg - {8'h00, n}) : rec_reg;
    assign line_cnt  = line_open ? n : line_reg;
    assign base      = line_open ? (n + addr_reg[15:8] + addr_reg[7:0]) : chk_reg;
    assign sum       = base + b;
    assign end_ck    = 8'd0 - (b + addr_reg[7:0] + 8'd1);

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        rec_next    = rec_reg;
        addr_next   = addr_reg;
        line_next   = line_reg;
        chk_next    = chk_reg;
        halted_next = halted_reg;
        job_valid   = 1'b0;
        job         = '0;

        if (take && !halted_reg)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    if (b < o2h_pkg::TYPE_MIN || b >= o2h_pkg::TYPE_LIMIT || b[0])
                    begin
                        job_valid   = 1'b1;
                        job.start   = o2h_pkg::SLOT_ERR;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        type_next  = b;
                        phase_next = PH_LEN_LO;
                    end
                end
                PH_LEN_LO:
                begin
                    rec_next   = {8'h00, b};
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    rec_next = len;
                    if (type_reg == o2h_pkg::TYPE_MODEND)
                    begin
                        phase_next = PH_END_MOD;
                    end
                    else if (type_reg == o2h_pkg::TYPE_CONTENT)
                    begin
                        if (len < 16'd4)
                        begin
                            job_valid   = 1'b1;
                            job.start   = o2h_pkg::SLOT_ERR;
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            rec_next   = len - 16'd4;
                            phase_next = PH_SEG;
                        end
                    end
                    else
                    begin
                        phase_next = (len != 16'd0) ? PH_SKIP : PH_TYPE;
                    end
                end
                PH_SKIP:
                begin
                    rec_next = rec_reg - 16'd1;
                    if (rec_reg == 16'd1)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_SEG:
                begin
                    phase_next = PH_ADDR_LO;
                end
                PH_ADDR_LO:
                begin
                    addr_next  = {8'h00, b};
                    phase_next = PH_ADDR_HI;
                end
                PH_ADDR_HI:
                begin
                    addr_next  = {b, addr_reg[7:0]};
                    line_next  = 8'd0;
                    phase_next = (rec_reg != 16'd0) ? PH_DATA : PH_JUNK;
                end
                PH_DATA:
                begin
                    rec_next  = rec_after;
                    line_next = line_cnt - 8'd1;
                    chk_next  = sum;
                    if (line_open)
                    begin
                        addr_next = addr_reg + {8'h00, n};
                    end
                    job_valid    = 1'b1;
                    job.hdr      = {n, addr_reg[15:8], addr_reg[7:0], 8'h00};
                    job.data     = b;
                    job.tail     = 8'd0 - sum;
                    job.start    = line_open ? o2h_pkg::SLOT_COLON : o2h_pkg::SLOT_DATA_HI;
                    job.tail_hex = (line_cnt == 8'd1);
                    job.newline  = (line_cnt == 8'd1);
                    if (line_cnt == 8'd1 && rec_after == 16'd0)
                    begin
                        phase_next = PH_JUNK;
                    end
                end
                PH_JUNK:
                begin
                    phase_next = PH_TYPE;
                end
                PH_END_MOD:
                begin
                    phase_next = PH_END_SEG;
                end
                PH_END_SEG:
                begin
                    phase_next = PH_END_ALO;
                end
                PH_END_ALO:
                begin
                    addr_next  = {8'h00, b};
                    phase_next = PH_END_AHI;
                end
                PH_END_AHI:
                begin
                    addr_next   = {b, addr_reg[7:0]};
                    job_valid   = 1'b1;
                    job.hdr     = {8'h00, b, addr_reg[7:0], 8'h01};
                    job.data    = end_ck;
                    job.start   = o2h_pkg::SLOT_COLON;
                    job.newline = 1'b1;
                    job.fin     = 1'b1;
                    phase_next  = PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;   // done: swallow everything
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_TYPE;
            type_reg     <= 8'd0;
            rec_reg      <= 16'd0;
            addr_reg     <= 16'd0;
            line_reg     <= 8'd0;
            chk_reg      <= 8'd0;
            halted_reg   <= 1'b0;
            max_line_reg <= MAX_LINE_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            rec_reg    <= rec_next;
            addr_reg   <= addr_next;
            line_reg   <= line_next;
            chk_reg    <= chk_next;
            halted_reg <= halted_next;
            if (cfg_we)
            begin
                max_line_reg <= cfg_wdata;
            end
        end
    end

endmodule

FILE: rtl/o2h_emitter.sv
// o2h_emitter: holds one character job and plays it out through a registered
// output stage, one char per cycle unless stalled. Depends on o2h_pkg and o2h_if.
module o2h_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  o2h_pkg::o2h_job_t job,
    output logic              job_ready,
    o2h_char_if.source        char_out
);

    o2h_pkg::o2h_job_t            job_reg;
    logic                         busy_reg;
    logic [o2h_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic                         ovalid_reg;
    logic [7:0]                   ochar_reg;
    logic                         olast_reg, obad_reg, ofin_reg;

    logic        adv;
    logic        done;
    logic [7:0]  ch;
    logic [2:0]  k;

    assign adv       = !ovalid_reg || char_out.ready;
    assign job_ready = !busy_reg || (adv && done);
    assign k         = 3'(slot_reg - 4'd1);

    // slot sequencing
    always_comb
    begin
        done      = 1'b0;
        slot_next = slot_reg + 4'd1;
        case (slot_reg)
            o2h_pkg::SLOT_DATA_LO:
            begin
                if (job_reg.tail_hex)
                begin
                    slot_next = o2h_pkg::SLOT_TAIL_HI;
                end
                else if (job_reg.newline)
                begin
                    slot_next = o2h_pkg::SLOT_NL;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            o2h_pkg::SLOT_NL,
            o2h_pkg::SLOT_ERR:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    // character for the current slot
    always_comb
    begin
        case (slot_reg)
            o2h_pkg::SLOT_COLON:   ch = o2h_pkg::CHAR_COLON;
            o2h_pkg::SLOT_DATA_HI: ch = o2h_pkg::hex_digit(job_reg.data[7:4]);
            o2h_pkg::SLOT_DATA_LO: ch = o2h_pkg::hex_digit(job_reg.data[3:0]);
            o2h_pkg::SLOT_TAIL_HI: ch = o2h_pkg::hex_digit(job_reg.tail[7:4]);
            o2h_pkg::SLOT_TAIL_LO: ch = o2h_pkg::hex_digit(job_reg.tail[3:0]);
            o2h_pkg::SLOT_NL:      ch = o2h_pkg::CHAR_NL;
            o2h_pkg::SLOT_ERR:     ch = o2h_pkg::CHAR_ERR;
            default:
            begin
                // header nibbles, first byte high
                if (slot_reg <= o2h_pkg::SLOT_HDR_END)
                begin
                    ch = o2h_pkg::hex_digit(job_reg.hdr[{~k, 2'b00} +: 4]);
                end
                else
                begin
                    ch = o2h_pkg::CHAR_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            slot_reg   <= o2h_pkg::SLOT_COLON;
        end
        else
        begin
            if (adv)
            begin
                ovalid_reg <= busy_reg;
            end
            if (job_valid && job_ready)
            begin
                busy_reg <= 1'b1;
                slot_reg <= job.start;
            end
            else if (busy_reg && adv)
            begin
                if (done)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    slot_reg <= slot_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            job_reg <= job;
        end
        if (adv && busy_reg)
        begin
            ochar_reg <= ch;
            olast_reg <= done;
            obad_reg  <= (slot_reg == o2h_pkg::SLOT_ERR);
            ofin_reg  <= job_reg.fin;
        end
    end

    assign char_out.valid       = ovalid_reg;
    assign char_out.out_char    = ochar_reg;
    assign char_out.last_of_run = olast_reg;
    assign char_out.bad_record  = obad_reg;
    assign char_out.finished    = ofin_reg;

endmodule

FILE: rtl/object_to_hex_record_converter.sv
// object_to_hex_record_converter: top level, 8080 object bytes in, Intel HEX text out.
// Depends on o2h_pkg, o2h_if, o2h_parser and o2h_emitter.
//
//   channel   | dir | handshake       | payload
//   ----------+-----+-----------------+---------------------------------------------
//   byte_in   | in  | valid/ready     | in_byte[7:0]
//   char_out  | out | valid/ready     | out_char[7:0], last_of_run, bad_record, finished
//   cfg       | in  | cfg_we (no ack) | cfg_wdata[7:0] = max_line_bytes
//
// Each accepted word produces as many characters as its job holds: a mid-line data
// byte gives 2 characters, a line's first byte adds 9 (colon and header), its last
// adds 3 (checksum and newline), the end line gives 12; some words produce none.
// The single job slot in the emitter means that a new word is taken in the cycle
// the previous job's last character moves into the output register.
// Reset (rst_n low, async) returns to waiting for a record type, line size 16.
// A stall on char_out holds the output register and, once the job slot is done,
// backs up into byte_in.ready.
module object_to_hex_record_converter #(
    parameter logic [7:0] MAX_LINE_RESET = o2h_pkg::MAX_LINE_RESET
) (
    input  logic       clk,
    input  logic       rst_n,
    o2h_byte_if.sink   byte_in,
    o2h_char_if.source char_out,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    o2h_pkg::o2h_job_t job;
    logic              job_valid;
    logic              job_ready;

    // record parsing: state update and job build happen in the accept cycle
    o2h_parser #(
        .MAX_LINE_RESET (MAX_LINE_RESET)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_in),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .job_ready (job_ready),
        .job_valid (job_valid),
        .job       (job)
    );

    // character playout with registered output
    o2h_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .char_out  (char_out)
    );

endmodule

FILE: rtl/o2h_checker.sv
// o2h_checker: port-level assertions for the converter, bound to the top level.
// Depends on object_to_hex_record_converter.
module o2h_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_char,
    input logic       last_of_run,
    input logic       bad_record,
    input logic       finished
);

    // error word is a lone null character
    a_bad_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_record |-> out_char == 8'h00 && last_of_run && !finished)
        else $error("bad_record word malformed");

    // end line closes with a newline
    a_fin_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && finished && last_of_run |-> out_char == 8'h0A)
        else $error("end line not closed by newline");

    // nothing follows an error
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && bad_record |=> !out_valid)
        else $error("output after error");

    // nothing follows the end line
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && finished && last_of_run |=> !out_valid)
        else $error("output after end line");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char))
        else $error("stalled output changed");

endmodule

bind object_to_hex_record_converter o2h_checker u_o2h_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (char_out.valid),
    .out_ready   (char_out.ready),
    .out_char    (char_out.out_char),
    .last_of_run (char_out.last_of_run),
    .bad_record  (char_out.bad_record),
    .finished    (char_out.finished)
);

FILE: verif/object_to_hex_record_converter_tb.sv
`timescale 1ns / 100ps
// object_to_hex_record_converter_tb: self-checking bench, object bytes in, hex characters out.
// Uses o2h_pkg, o2h_if and the converter RTL; predicts every character from its own parser copy.
module object_to_hex_record_converter_tb;

    // ------------------------------------------------------------------
    // Clock, reset, channels
    // ------------------------------------------------------------------
    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    o2h_byte_if byte_bus ();
    o2h_char_if char_bus ();

    object_to_hex_record_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_bus),
        .char_out  (char_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block wedges (e.g. ready never comes back).
    initial
    begin
        #5_000_000;
        $display("object_to_hex_record_converter test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Parser copy used to predict the hex text
    // ------------------------------------------------------------------
    typedef enum logic [3:0] {
        WAIT_TYPE, LEN_LO, LEN_HI, SKIP_BODY, SEG, ADDR_LO, ADDR_HI, DATA,
        CKSUM, END_MOD, END_SEG, END_ADDR_LO, END_ADDR_HI, DONE
    } parse_phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
        logic       fin;
    } hex_char_t;

    parse_phase_t phase;
    logic [7:0]   rec_type;
    logic [15:0]  rec_left;
    logic [15:0]  load_addr;
    logic [7:0]   line_left;
    logic [7:0]   line_sum;
    logic         stopped;
    logic [7:0]   line_max;

    hex_char_t  run_chars[$];    // characters caused by the word being predicted
    hex_char_t  hex_expect[$];   // characters still owed by the block
    logic [7:0] obj_bytes_pending[$];

    int  err_count;
    int  sent_count;
    int  idle_pct;
    int  send_gap;
    int  recv_gap;
    bit  word_taken;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h41 + {4'h0, nib} - 8'd10);
    endfunction

    function automatic void emit(input logic [7:0] c, input logic bad, input logic fin);
        run_chars.push_back('{c, 1'b0, bad, fin});
    endfunction

    function automatic void emit_hex(input logic [7:0] v, input logic fin);
        emit(hex_ascii(v[7:4]), 1'b0, fin);
        emit(hex_ascii(v[3:0]), 1'b0, fin);
    endfunction

    // Advance the parser copy by one object byte and queue what it prints.
    function automatic void predict_hex_text(input logic [7:0] b);
        logic [7:0] lim;
        logic [7:0] n;
        logic [7:0] ck;
        run_chars.delete();
        if (!stopped && phase != DONE)
        begin
            case (phase)
                WAIT_TYPE:
                begin
                    if (b < o2h_pkg::TYPE_MIN || b >= o2h_pkg::TYPE_LIMIT || b[0])
                    begin
                        emit(o2h_pkg::CHAR_ERR, 1'b1, 1'b0);
                        stopped = 1'b1;
                    end
                    else
                    begin
                        rec_type = b;
                        phase    = LEN_LO;
                    end
                end
                LEN_LO:
                begin
                    rec_left = {8'h00, b};
                    phase    = LEN_HI;
                end
                LEN_HI:
                begin
                    rec_left[15:8] = b;
                    if (rec_type == o2h_pkg::TYPE_MODEND)
                    begin
                        phase = END_MOD;
                    end
                    else if (rec_type == o2h_pkg::TYPE_CONTENT)
                    begin
                        // segment + address + checksum must fit in the length
                        if (rec_left < 16'd4)
                        begin
                            emit(o2h_pkg::CHAR_ERR, 1'b1, 1'b0);
                            stopped = 1'b1;
                        end
                        else
                        begin
                            rec_left = rec_left - 16'd4;
                            phase    = SEG;
                        end
                    end
                    else
                    begin
                        phase = (rec_left != 16'd0) ? SKIP_BODY : WAIT_TYPE;
                    end
                end
                SKIP_BODY:
                begin
                    rec_left = rec_left - 16'd1;
                    if (rec_left == 16'd0)
                    begin
                        phase = WAIT_TYPE;
                    end
                end
                SEG:
                begin
                    phase = ADDR_LO;
                end
                ADDR_LO:
                begin
                    load_addr = {8'h00, b};
                    phase     = ADDR_HI;
                end
                ADDR_HI:
                begin
                    load_addr[15:8] = b;
                    line_left       = 8'd0;
                    phase           = (rec_left != 16'd0) ? DATA : CKSUM;
                end
                DATA:
                begin
                    // new line: header goes out with the first data byte
                    if (line_left == 8'd0)
                    begin
                        lim       = (line_max != 8'd0) ? line_max : 8'd1;
                        n         = (rec_left > {8'h00, lim}) ? lim : rec_left[7:0];
                        rec_left  = rec_left - {8'h00, n};
                        line_left = n;
                        line_sum  = n + load_addr[15:8] + load_addr[7:0];
                        emit(o2h_pkg::CHAR_COLON, 1'b0, 1'b0);
                        emit_hex(n, 1'b0);
                        emit_hex(load_addr[15:8], 1'b0);
                        emit_hex(load_addr[7:0], 1'b0);
                        emit_hex(8'h00, 1'b0);
                        load_addr = load_addr + {8'h00, n};
                    end
                    line_sum = line_sum + b;
                    emit_hex(b, 1'b0);
                    line_left = line_left - 8'd1;
                    // line closes: checksum and newline ride on the last data byte
                    if (line_left == 8'd0)
                    begin
                        emit_hex(8'h00 - line_sum, 1'b0);
                        emit(o2h_pkg::CHAR_NL, 1'b0, 1'b0);
                        if (rec_left == 16'd0)
                        begin
                            phase = CKSUM;
                        end
                    end
                end
                CKSUM:
                begin
                    phase = WAIT_TYPE;   // object checksum is dropped unchecked
                end
                END_MOD:
                begin
                    phase = END_SEG;
                end
                END_SEG:
                begin
                    phase = END_ADDR_LO;
                end
                END_ADDR_LO:
                begin
                    load_addr = {8'h00, b};
                    phase     = END_ADDR_HI;
                end
                default:
                begin
                    load_addr[15:8] = b;
                    ck = 8'h00 - (b + load_addr[7:0] + 8'd1);
                    emit(o2h_pkg::CHAR_COLON, 1'b0, 1'b1);
                    emit_hex(8'h00, 1'b1);
                    emit_hex(b, 1'b1);
                    emit_hex(load_addr[7:0], 1'b1);
                    emit_hex(8'h01, 1'b1);
                    emit_hex(ck, 1'b1);
                    emit(o2h_pkg::CHAR_NL, 1'b0, 1'b1);
                    phase = DONE;
                end
            endcase
        end
        if (run_chars.size() > 0)
        begin
            run_chars[$].last = 1'b1;
        end
        foreach (run_chars[i])
        begin
            hex_expect.push_back(run_chars[i]);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: sender and receiver both change at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // sender: a word stays on the bus until it is taken
            if (byte_bus.valid && !word_taken)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                byte_bus.valid <= 1'b0;
            end
            else if (obj_bytes_pending.size() > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap = $urandom_range(0, 4);   // random burst of idle cycles
                byte_bus.valid <= 1'b0;
            end
            else if (obj_bytes_pending.size() > 0)
            begin
                byte_bus.valid   <= 1'b1;
                byte_bus.in_byte <= obj_bytes_pending[0];
            end
            else
            begin
                byte_bus.valid <= 1'b0;
            end
            word_taken = 1'b0;

            // receiver: random stall bursts
            if (recv_gap > 0)
            begin
                recv_gap--;
                char_bus.ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                recv_gap = $urandom_range(0, 4);
                char_bus.ready <= 1'b0;
            end
            else
            begin
                char_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on accepted input first, then check the output word.
    // A character can never leave in the same cycle its byte is taken, so
    // doing both in one block keeps the order fixed.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        hex_char_t got;
        hex_char_t want;
        if (rst_n)
        begin
            if (byte_bus.valid && byte_bus.ready)
            begin
                predict_hex_text(byte_bus.in_byte);
                void'(obj_bytes_pending.pop_front());
                word_taken = 1'b1;
            end
            if (char_bus.valid && char_bus.ready)
            begin
                got = '{char_bus.out_char, char_bus.last_of_run,
                        char_bus.bad_record, char_bus.finished};
                if (hex_expect.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected char %02h last %b bad %b fin %b",
                                              got.ch, got.last, got.bad, got.fin));
                end
                else
                begin
                    want = hex_expect.pop_front();
                    if (got.ch !== want.ch || got.last !== want.last ||
                        got.bad !== want.bad || got.fin !== want.fin)
                    begin
                        report_mismatch($sformatf(
                            "char %02h/%02h last %b/%b bad %b/%b fin %b/%b (got/exp)",
                            got.ch, want.ch, got.last, want.last,
                            got.bad, want.bad, got.fin, want.fin));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Object stream builders
    // ------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] b);
        obj_bytes_pending.push_back(b);
        sent_count++;
    endtask

    // content record: type, length, segment, address, n data bytes, checksum
    task automatic send_content(input logic [15:0] addr, input int n);
        logic [15:0] len;
        len = 16'(n + 4);
        put_byte(o2h_pkg::TYPE_CONTENT);
        put_byte(len[7:0]);
        put_byte(len[15:8]);
        put_byte(8'($urandom_range(0, 255)));
        put_byte(addr[7:0]);
        put_byte(addr[15:8]);
        repeat (n)
        begin
            put_byte(8'($urandom_range(0, 255)));
        end
        put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic send_skip(input logic [7:0] kind, input int len);
        put_byte(kind);
        put_byte(8'(len));
        put_byte(8'(len >> 8));
        repeat (len)
        begin
            put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    function automatic logic [7:0] pick_skip_type();
        logic [7:0] t;
        t = o2h_pkg::TYPE_MODEND;
        while (t == o2h_pkg::TYPE_MODEND || t == o2h_pkg::TYPE_CONTENT)
        begin
            t = 8'($urandom_range(o2h_pkg::TYPE_MIN / 2,
                                 (o2h_pkg::TYPE_LIMIT - 8'd2) / 2) * 2);
        end
        return t;
    endfunction

    // Block must be quiet before a register write: nothing queued, nothing
    // owed, plus slack for a word that prints nothing.
    task automatic wait_drained(input int settle);
        while (obj_bytes_pending.size() != 0 || byte_bus.valid || hex_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_line_max(input logic [7:0] v);
        @(negedge clk);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        line_max = v;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0]  sizes[8];
        logic [7:0]  bad_types[6];
        logic [15:0] addr;
        int          pass_no;
        int          kind;

        sizes     = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd7, o2h_pkg::MAX_LINE_RESET, 8'd255, 8'd5};
        bad_types = '{8'h00, o2h_pkg::TYPE_MIN - 8'd1, o2h_pkg::TYPE_MIN + 8'd1,
                      o2h_pkg::TYPE_LIMIT - 8'd1, o2h_pkg::TYPE_LIMIT, 8'hFF};

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = 8'h00;
        byte_bus.valid   = 1'b0;
        byte_bus.in_byte = 8'h00;
        char_bus.ready   = 1'b0;
        err_count        = 0;
        sent_count       = 0;
        idle_pct         = 20;
        send_gap         = 0;
        recv_gap         = 0;
        word_taken       = 1'b0;

        phase     = WAIT_TYPE;
        rec_type  = 8'h00;
        rec_left  = 16'h0000;
        load_addr = 16'h0000;
        line_left = 8'h00;
        line_sum  = 8'h00;
        stopped   = 1'b0;
        line_max  = o2h_pkg::MAX_LINE_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty skip at the bottom of the type range, skip with extreme
        // body bytes at the top of it, content with no data at the top address,
        // then a short line at address zero under the reset line size.
        send_skip(o2h_pkg::TYPE_MIN, 0);
        put_byte(o2h_pkg::TYPE_LIMIT - 8'd2);
        put_byte(8'd2);
        put_byte(8'd0);
        put_byte(8'hFF);
        put_byte(8'h00);
        send_content(16'hFFFF, 0);
        send_content(16'h0000, 3);

        // Random: each pass drains the block (sender held until every char
        // is back), sets a new line size and runs a few records.
        pass_no = 0;
        while (sent_count < 175)
        begin
            wait_drained(24);
            write_line_max((pass_no < 8) ? sizes[pass_no] : 8'($urandom_range(0, 255)));
            pass_no++;
            case ($urandom_range(0, 3))
                0: idle_pct = 0;
                1: idle_pct = 10;
                2: idle_pct = 25;
                default: idle_pct = 40;
            endcase
            repeat ($urandom_range(2, 4))
            begin
                kind = $urandom_range(0, 9);
                addr = 16'($urandom_range(0, 65535));
                if (kind == 0)
                begin
                    send_content(addr | 16'hFFF0, $urandom_range(20, 40));
                end
                else if (kind < 7)
                begin
                    send_content(addr, $urandom_range(0, 12));
                end
                else
                begin
                    send_skip(pick_skip_type(), $urandom_range(0, 5));
                end
            end
        end

        // Last part: no idling. One more record, then a terminating event,
        // then bytes that must be swallowed silently.
        wait_drained(24);
        idle_pct = 0;
        send_content(16'($urandom_range(0, 65535)), $urandom_range(1, 20));
        case ($urandom_range(0, 3))
            0:
            begin
                // end of module with its start address
                put_byte(o2h_pkg::TYPE_MODEND);
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
                put_byte(8'($urandom_range(0, 255)));
            end
            1:
            begin
                put_byte(bad_types[$urandom_range(0, 5)]);
            end
            2:
            begin
                put_byte(8'($urandom_range(0, 127) * 2 + 1));   // any odd type
            end
            default:
            begin
                // content length too short to hold segment, address and checksum
                put_byte(o2h_pkg::TYPE_CONTENT);
                put_byte(8'($urandom_range(0, 3)));
                put_byte(8'h00);
            end
        endcase
        send_content(16'($urandom_range(0, 65535)), 2);
        repeat ($urandom_range(3, 8))
        begin
            put_byte(8'($urandom_range(0, 255)));
        end

        wait_drained(40);
        if (hex_expect.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected chars never came", hex_expect.size()));
        end
        if (err_count == 0)
        begin
            $display("object_to_hex_record_converter test passed");
        end
        else
        begin
            $display("object_to_hex_record_converter test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/o2h_pkg.sv
rtl/o2h_if.sv
rtl/o2h_parser.sv
rtl/o2h_emitter.sv
rtl/object_to_hex_record_converter.sv
rtl/o2h_checker.sv
verif/object_to_hex_record_converter_tb.sv
